FILE: rtl/ppe_pkg.sv
// Package with shared types, register indexes and trig constants for the pivot rotator.
`default_nettype none
package ppe_pkg;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int ANGLE_BITS      = 32;
    localparam int COEF_WIDTH      = 32;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ANGLE_X = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ANGLE_Y = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ANGLE_Z = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PIVOT_X = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PIVOT_Y = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PIVOT_Z = 3'd5;

    // pi in Q2.30, rounded.
    localparam logic [31:0] PI_Q30 = 32'hC90F_DAA2;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    localparam int SIN_STEPS = 6;
    localparam int COS_STEPS = 7;

    localparam logic [63:0] RECIP_NUM = 64'h8000_0000;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] k11;
        logic signed [COEF_WIDTH-1:0] k12;
        logic signed [COEF_WIDTH-1:0] k21;
        logic signed [COEF_WIDTH-1:0] k22;
    } coef_t;

    // Horner divisors: sine series first, then cosine series.
    function automatic logic [7:0] horner_div(input logic is_cos, input logic [2:0] step);
        logic [7:0] k;
        k = 8'd1;
        unique case ({is_cos, step})
            4'b0000: k = 8'd156;
            4'b0001: k = 8'd110;
            4'b0010: k = 8'd72;
            4'b0011: k = 8'd42;
            4'b0100: k = 8'd20;
            4'b0101: k = 8'd6;
            4'b1000: k = 8'd182;
            4'b1001: k = 8'd132;
            4'b1010: k = 8'd90;
            4'b1011: k = 8'd56;
            4'b1100: k = 8'd30;
            4'b1101: k = 8'd12;
            4'b1110: k = 8'd2;
            default: k = 8'd1;
        endcase
        return k;
    endfunction

    // Reciprocals floor(2^31 / k) of the Horner divisors, in the same order.
    function automatic logic [31:0] horner_recip(input logic is_cos, input logic [2:0] step);
        logic [31:0] m;
        m = 32'(RECIP_NUM);
        unique case ({is_cos, step})
            4'b0000: m = 32'(RECIP_NUM / 64'd156);
            4'b0001: m = 32'(RECIP_NUM / 64'd110);
            4'b0010: m = 32'(RECIP_NUM / 64'd72);
            4'b0011: m = 32'(RECIP_NUM / 64'd42);
            4'b0100: m = 32'(RECIP_NUM / 64'd20);
            4'b0101: m = 32'(RECIP_NUM / 64'd6);
            4'b1000: m = 32'(RECIP_NUM / 64'd182);
            4'b1001: m = 32'(RECIP_NUM / 64'd132);
            4'b1010: m = 32'(RECIP_NUM / 64'd90);
            4'b1011: m = 32'(RECIP_NUM / 64'd56);
            4'b1100: m = 32'(RECIP_NUM / 64'd30);
            4'b1101: m = 32'(RECIP_NUM / 64'd12);
            4'b1110: m = 32'(RECIP_NUM / 64'd2);
            default: m = 32'(RECIP_NUM);
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/ppe_if.sv
// Valid/ready channel interfaces for input points and rotated results.
`default_nettype none
interface ppe_in_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;
    logic signed [W-1:0] point_z;
    modport source (output valid, output point_x, output point_y, output point_z, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface ppe_out_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] rotated_x;
    logic signed [W-1:0] rotated_y;
    logic signed [W-1:0] rotated_z;
    logic                overflow;
    modport source (output valid, output rotated_x, output rotated_y, output rotated_z,
                    output overflow, input ready);
    modport sink   (input valid, input rotated_x, input rotated_y, input rotated_z,
                    input overflow, output ready);
endinterface
`default_nettype wire

FILE: rtl/ppe_trig.sv
// Sequential sine/cosine unit: shared multiplier and reciprocal division, one axis at a time.
`default_nettype none
module ppe_trig #(
    parameter int ANGLE_WIDTH = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [ANGLE_WIDTH-1:0] angle_x,
    input  wire logic [ANGLE_WIDTH-1:0] angle_y,
    input  wire logic [ANGLE_WIDTH-1:0] angle_z,
    output logic                        busy,
    output logic signed [ppe_pkg::COEF_WIDTH-1:0] cos_x,
    output logic signed [ppe_pkg::COEF_WIDTH-1:0] sin_x,
    output logic signed [ppe_pkg::COEF_WIDTH-1:0] cos_y,
    output logic signed [ppe_pkg::COEF_WIDTH-1:0] sin_y,
    output logic signed [ppe_pkg::COEF_WIDTH-1:0] cos_z,
    output logic signed [ppe_pkg::COEF_WIDTH-1:0] sin_z
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PREP = 4'd1;
    localparam logic [3:0] ST_XM   = 4'd2;
    localparam logic [3:0] ST_XMR  = 4'd3;
    localparam logic [3:0] ST_X2   = 4'd4;
    localparam logic [3:0] ST_X2R  = 4'd5;
    localparam logic [3:0] ST_HM   = 4'd6;
    localparam logic [3:0] ST_HD   = 4'd7;
    localparam logic [3:0] ST_QM   = 4'd8;
    localparam logic [3:0] ST_HT   = 4'd9;
    localparam logic [3:0] ST_SM   = 4'd10;
    localparam logic [3:0] ST_SR   = 4'd11;
    localparam logic [3:0] ST_MAP  = 4'd12;
    localparam logic [3:0] ST_QR   = 4'd13;
    localparam logic [3:0] ST_QC   = 4'd14;

    localparam int CW = ppe_pkg::COEF_WIDTH;

    logic [3:0]  state_reg;
    logic [1:0]  axis_reg;
    logic        phase_reg;
    logic [2:0]  step_reg;
    logic [1:0]  q_reg;
    logic        neg_reg;
    logic [29:0] rmag_reg;
    logic [63:0] prod_reg;
    logic [30:0] xm_reg;
    logic [30:0] x2_reg;
    logic [30:0] t_reg;
    logic [30:0] smag_reg;
    logic [31:0] dvd_reg;
    logic [31:0] quo_reg;
    logic signed [CW-1:0] cos_reg [3];
    logic signed [CW-1:0] sin_reg [3];

    logic [ANGLE_WIDTH-1:0] ang_sel;
    logic [31:0] a_full;
    logic [31:0] a_round;
    logic [1:0]  q_next;
    logic [31:0] u_val;
    logic [31:0] u_mag;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [7:0]  kdiv;
    logic [31:0] recip;
    logic [31:0] rem_val;
    logic        q_fix;
    logic [63:0] hd_sum;
    logic [63:0] rnd31;
    logic [63:0] rnd29;
    logic [31:0] t_new;
    logic signed [CW-1:0] c_val;
    logic signed [CW-1:0] s_val;
    logic signed [CW-1:0] cos_m;
    logic signed [CW-1:0] sin_m;

    always_comb
    begin
        unique case (axis_reg)
            2'd0:    ang_sel = angle_x;
            2'd1:    ang_sel = angle_y;
            default: ang_sel = angle_z;
        endcase
        // Only the top angle bits are stored; the rest read as zero.
        a_full  = 32'(ang_sel) << (ppe_pkg::ANGLE_BITS - ANGLE_WIDTH);
        a_round = a_full + 32'h2000_0000;
        q_next  = a_round[31:30];
        u_val   = a_full - {q_next, 30'd0};
        u_mag   = u_val[31] ? (32'd0 - u_val) : u_val;
    end

    always_comb
    begin
        unique case (state_reg)
            ST_XM:
            begin
                mul_a = 32'(rmag_reg);
                mul_b = ppe_pkg::PI_Q30;
            end
            ST_X2:
            begin
                mul_a = 32'(xm_reg);
                mul_b = 32'(xm_reg);
            end
            ST_SM:
            begin
                mul_a = 32'(xm_reg);
                mul_b = 32'(t_reg);
            end
            ST_QM:
            begin
                mul_a = dvd_reg;
                mul_b = recip;
            end
            default:
            begin
                mul_a = 32'(x2_reg);
                mul_b = 32'(t_reg);
            end
        endcase
    end

    always_comb
    begin
        kdiv    = ppe_pkg::horner_div(phase_reg, step_reg);
        recip   = ppe_pkg::horner_recip(phase_reg, step_reg);
        rem_val = dvd_reg - (quo_reg * 32'(kdiv));
        q_fix   = (rem_val >= 32'(kdiv));
        hd_sum  = prod_reg + (64'(kdiv) << 29);
        rnd31   = prod_reg + (64'd1 << 31);
        rnd29   = prod_reg + (64'd1 << 29);
        t_new   = 32'(ppe_pkg::Q30_ONE) - quo_reg;
        s_val   = neg_reg ? -CW'($signed({1'b0, smag_reg})) : CW'($signed({1'b0, smag_reg}));
        c_val   = CW'($signed({1'b0, t_reg}));
        unique case (q_reg)
            2'd0:
            begin
                cos_m = c_val;
                sin_m = s_val;
            end
            2'd1:
            begin
                cos_m = -s_val;
                sin_m = c_val;
            end
            2'd2:
            begin
                cos_m = -c_val;
                sin_m = -s_val;
            end
            default:
            begin
                cos_m = s_val;
                sin_m = -c_val;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 2'd0;
            phase_reg <= 1'b0;
            step_reg  <= 3'd0;
            // Zero angles give the identity rotation.
            for (int i = 0; i < 3; i++)
            begin
                cos_reg[i] <= CW'($signed({1'b0, ppe_pkg::Q30_ONE}));
                sin_reg[i] <= '0;
            end
        end
        else if (start)
        begin
            state_reg <= ST_PREP;
            axis_reg  <= 2'd0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE: state_reg <= ST_IDLE;
                ST_PREP:
                begin
                    q_reg     <= q_next;
                    neg_reg   <= u_val[31];
                    rmag_reg  <= u_mag[29:0];
                    state_reg <= ST_XM;
                end
                ST_XM: state_reg <= ST_XMR;
                ST_XMR:
                begin
                    xm_reg    <= rnd31[62:32];
                    state_reg <= ST_X2;
                end
                ST_X2: state_reg <= ST_X2R;
                ST_X2R:
                begin
                    x2_reg    <= rnd29[60:30];
                    t_reg     <= ppe_pkg::Q30_ONE;
                    phase_reg <= 1'b0;
                    step_reg  <= 3'd0;
                    state_reg <= ST_HM;
                end
                ST_HM: state_reg <= ST_HD;
                ST_HD:
                begin
                    dvd_reg   <= hd_sum[61:30];
                    state_reg <= ST_QM;
                end
                ST_QM: state_reg <= ST_QR;
                ST_QR:
                begin
                    quo_reg   <= prod_reg[62:31];
                    state_reg <= ST_QC;
                end
                ST_QC:
                begin
                    // The reciprocal estimate is at most one short of the true quotient.
                    quo_reg   <= quo_reg + {31'd0, q_fix};
                    state_reg <= ST_HT;
                end
                ST_HT:
                begin
                    t_reg <= t_new[30:0];
                    if (!phase_reg && step_reg == 3'(ppe_pkg::SIN_STEPS - 1))
                    begin
                        state_reg <= ST_SM;
                    end
                    else if (phase_reg && step_reg == 3'(ppe_pkg::COS_STEPS - 1))
                    begin
                        state_reg <= ST_MAP;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 3'd1;
                        state_reg <= ST_HM;
                    end
                end
                ST_SM: state_reg <= ST_SR;
                ST_SR:
                begin
                    smag_reg  <= rnd29[60:30];
                    t_reg     <= ppe_pkg::Q30_ONE;
                    phase_reg <= 1'b1;
                    step_reg  <= 3'd0;
                    state_reg <= ST_HM;
                end
                ST_MAP:
                begin
                    cos_reg[axis_reg] <= cos_m;
                    sin_reg[axis_reg] <= sin_m;
                    if (axis_reg == 2'd2)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_PREP;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy  = (state_reg != ST_IDLE);
    assign cos_x = cos_reg[0];
    assign sin_x = sin_reg[0];
    assign cos_y = cos_reg[1];
    assign sin_y = sin_reg[1];
    assign cos_z = cos_reg[2];
    assign sin_z = sin_reg[2];

endmodule
`default_nettype wire

FILE: rtl/ppe_rot.sv
// Two-stage planar rotation: split partial products, then rounded sums.
`default_nettype none
module ppe_rot #(
    parameter int DW = 34
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic signed [DW-1:0] a,
    input  wire logic signed [DW-1:0] b,
    input  wire ppe_pkg::coef_t       coef,
    output logic                      out_valid,
    output logic signed [DW-1:0]      a_out,
    output logic signed [DW-1:0]      b_out
);

    localparam int HW = DW - 30;
    localparam int KW = ppe_pkg::COEF_WIDTH;
    localparam int LW = 31 + KW;
    localparam int PW = HW + KW;
    localparam int SW = PW + 4;

    logic                 v1_reg;
    logic signed [LW-1:0] pl11_reg;
    logic signed [LW-1:0] pl12_reg;
    logic signed [LW-1:0] pl21_reg;
    logic signed [LW-1:0] pl22_reg;
    logic signed [PW-1:0] ph11_reg;
    logic signed [PW-1:0] ph12_reg;
    logic signed [PW-1:0] ph21_reg;
    logic signed [PW-1:0] ph22_reg;
    logic                 v2_reg;
    logic signed [DW-1:0] a_reg;
    logic signed [DW-1:0] b_reg;

    logic signed [30:0]   al;
    logic signed [30:0]   bl;
    logic signed [HW-1:0] ah;
    logic signed [HW-1:0] bh;
    logic signed [LW:0]   lo1;
    logic signed [LW:0]   lo2;
    logic signed [SW-1:0] sum1;
    logic signed [SW-1:0] sum2;

    // Each operand is split into a signed high part and an unsigned low 30 bits.
    assign al = $signed({1'b0, a[29:0]});
    assign bl = $signed({1'b0, b[29:0]});
    assign ah = a[DW-1:30];
    assign bh = b[DW-1:30];

    always_comb
    begin
        lo1  = (LW+1)'(pl11_reg) + (LW+1)'(pl12_reg) + (LW+1)'(64'sd1 << 29);
        lo2  = (LW+1)'(pl21_reg) + (LW+1)'(pl22_reg) + (LW+1)'(64'sd1 << 29);
        sum1 = SW'(ph11_reg) + SW'(ph12_reg) + SW'(lo1 >>> 30);
        sum2 = SW'(ph21_reg) + SW'(ph22_reg) + SW'(lo2 >>> 30);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl11_reg <= al * coef.k11;
            pl12_reg <= bl * coef.k12;
            pl21_reg <= al * coef.k21;
            pl22_reg <= bl * coef.k22;
            ph11_reg <= ah * coef.k11;
            ph12_reg <= bh * coef.k12;
            ph21_reg <= ah * coef.k21;
            ph22_reg <= bh * coef.k22;
            a_reg    <= DW'(sum1);
            b_reg    <= DW'(sum2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign a_out     = a_reg;
    assign b_out     = b_reg;

endmodule
`default_nettype wire

FILE: rtl/pivot_point_euler_rotation.sv
// Top level: config registers, trig unit and the eight-stage rotation pipeline.
//
//   channel     dir  handshake          payload
//   point_in    in   valid/ready        point_x, point_y, point_z
//   result_out  out  valid/ready        rotated_x, rotated_y, rotated_z, overflow
//   cfg         in   cfg_we             cfg_index, cfg_data
//
// One word per cycle is accepted while the pipeline advances and the sine/cosine unit is
// idle. Each word passes the input register, three rotators and the output register. The
// pipeline is stalled as a whole while the output register holds an untaken word. After
// reset the identity rotation is ready at once. A write to an angle register starts the
// sine/cosine unit; it holds point_in.ready low over three axes of thirteen series steps.
`default_nettype none
module pivot_point_euler_rotation #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [ppe_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [ppe_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    ppe_in_if.sink                                     point_in,
    ppe_out_if.source                                  result_out
);

    localparam int DW = (COORD_WIDTH + 2 > 32) ? COORD_WIDTH + 2 : 32;
    localparam int PVW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

    logic [ANGLE_WIDTH-1:0] ang_x_reg;
    logic [ANGLE_WIDTH-1:0] ang_y_reg;
    logic [ANGLE_WIDTH-1:0] ang_z_reg;
    logic [PVW-1:0]         piv_x_reg;
    logic [PVW-1:0]         piv_y_reg;
    logic [PVW-1:0]         piv_z_reg;

    logic trig_start;
    logic trig_busy;
    logic signed [ppe_pkg::COEF_WIDTH-1:0] cos_x, sin_x, cos_y, sin_y, cos_z, sin_z;
    ppe_pkg::coef_t coef_x, coef_y, coef_z;

    logic signed [DW-1:0] piv_x, piv_y, piv_z;

    logic adv;
    logic v0_reg;
    logic signed [DW-1:0] x0_reg, y0_reg, z0_reg;
    logic v1, v2, v3;
    logic signed [DW-1:0] x1, y1, x2, z2, y3, z3;
    logic signed [DW-1:0] z0d1_reg, z0d2_reg;
    logic signed [DW-1:0] y1d1_reg, y1d2_reg;
    logic signed [DW-1:0] x2d1_reg, x2d2_reg;

    logic out_valid_reg;
    logic signed [COORD_WIDTH-1:0] rx_reg, ry_reg, rz_reg;
    logic ovf_reg;

    logic signed [DW:0] fx, fy, fz;
    logic signed [COORD_WIDTH-1:0] sx, sy, sz;
    logic ox, oy, oz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_x_reg <= '0;
            ang_y_reg <= '0;
            ang_z_reg <= '0;
            piv_x_reg <= '0;
            piv_y_reg <= '0;
            piv_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ppe_pkg::CFG_ANGLE_X: ang_x_reg <= cfg_data[31 -: ANGLE_WIDTH];
                ppe_pkg::CFG_ANGLE_Y: ang_y_reg <= cfg_data[31 -: ANGLE_WIDTH];
                ppe_pkg::CFG_ANGLE_Z: ang_z_reg <= cfg_data[31 -: ANGLE_WIDTH];
                ppe_pkg::CFG_PIVOT_X: piv_x_reg <= cfg_data[PVW-1:0];
                ppe_pkg::CFG_PIVOT_Y: piv_y_reg <= cfg_data[PVW-1:0];
                ppe_pkg::CFG_PIVOT_Z: piv_z_reg <= cfg_data[PVW-1:0];
                default: ;
            endcase
        end
    end

    assign trig_start = cfg_we && (cfg_index == ppe_pkg::CFG_ANGLE_X
                                || cfg_index == ppe_pkg::CFG_ANGLE_Y
                                || cfg_index == ppe_pkg::CFG_ANGLE_Z);

    ppe_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (trig_start),
        .angle_x (ang_x_reg),
        .angle_y (ang_y_reg),
        .angle_z (ang_z_reg),
        .busy    (trig_busy),
        .cos_x   (cos_x),
        .sin_x   (sin_x),
        .cos_y   (cos_y),
        .sin_y   (sin_y),
        .cos_z   (cos_z),
        .sin_z   (sin_z)
    );

    // A pivot wider than the config word is zero-extended; otherwise its top bit is the sign.
    generate
        if (COORD_WIDTH > 32)
        begin : g_piv_zext
            assign piv_x = DW'($signed({1'b0, piv_x_reg}));
            assign piv_y = DW'($signed({1'b0, piv_y_reg}));
            assign piv_z = DW'($signed({1'b0, piv_z_reg}));
        end
        else
        begin : g_piv_sext
            assign piv_x = DW'($signed(piv_x_reg));
            assign piv_y = DW'($signed(piv_y_reg));
            assign piv_z = DW'($signed(piv_z_reg));
        end
    endgenerate

    always_comb
    begin
        coef_z = '{k11: cos_z, k12: -sin_z, k21: sin_z, k22: cos_z};
        coef_y = '{k11: cos_y, k12: sin_y, k21: -sin_y, k22: cos_y};
        coef_x = '{k11: cos_x, k12: -sin_x, k21: sin_x, k22: cos_x};
    end

    assign adv            = !out_valid_reg || result_out.ready;
    assign point_in.ready = adv && !trig_busy;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg   <= DW'(point_in.point_x) - piv_x;
            y0_reg   <= DW'(point_in.point_y) - piv_y;
            z0_reg   <= DW'(point_in.point_z) - piv_z;
            z0d1_reg <= z0_reg;
            z0d2_reg <= z0d1_reg;
            y1d1_reg <= y1;
            y1d2_reg <= y1d1_reg;
            x2d1_reg <= x2;
            x2d2_reg <= x2d1_reg;
            rx_reg   <= sx;
            ry_reg   <= sy;
            rz_reg   <= sz;
            ovf_reg  <= ox || oy || oz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg        <= point_in.valid && point_in.ready;
            out_valid_reg <= v3;
        end
    end

    ppe_rot #(.DW(DW)) u_rot_z (
        .clk (clk), .rst_n (rst_n), .en (adv), .in_valid (v0_reg),
        .a (x0_reg), .b (y0_reg), .coef (coef_z),
        .out_valid (v1), .a_out (x1), .b_out (y1)
    );

    ppe_rot #(.DW(DW)) u_rot_y (
        .clk (clk), .rst_n (rst_n), .en (adv), .in_valid (v1),
        .a (x1), .b (z0d2_reg), .coef (coef_y),
        .out_valid (v2), .a_out (x2), .b_out (z2)
    );

    ppe_rot #(.DW(DW)) u_rot_x (
        .clk (clk), .rst_n (rst_n), .en (adv), .in_valid (v2),
        .a (y1d2_reg), .b (z2), .coef (coef_x),
        .out_valid (v3), .a_out (y3), .b_out (z3)
    );

    localparam logic signed [DW:0] SAT_HI = (DW+1)'((65'sd1 <<< (COORD_WIDTH - 1)) - 65'sd1);
    localparam logic signed [DW:0] SAT_LO = -SAT_HI - (DW+1)'(1);

    always_comb
    begin
        fx = (DW+1)'(x2d2_reg) + (DW+1)'(piv_x);
        fy = (DW+1)'(y3) + (DW+1)'(piv_y);
        fz = (DW+1)'(z3) + (DW+1)'(piv_z);
        ox = (fx > SAT_HI) || (fx < SAT_LO);
        oy = (fy > SAT_HI) || (fy < SAT_LO);
        oz = (fz > SAT_HI) || (fz < SAT_LO);
        sx = (fx > SAT_HI) ? COORD_WIDTH'(SAT_HI) : (fx < SAT_LO) ? COORD_WIDTH'(SAT_LO)
                                                                   : COORD_WIDTH'(fx);
        sy = (fy > SAT_HI) ? COORD_WIDTH'(SAT_HI) : (fy < SAT_LO) ? COORD_WIDTH'(SAT_LO)
                                                                   : COORD_WIDTH'(fy);
        sz = (fz > SAT_HI) ? COORD_WIDTH'(SAT_HI) : (fz < SAT_LO) ? COORD_WIDTH'(SAT_LO)
                                                                   : COORD_WIDTH'(fz);
    end

    assign result_out.valid     = out_valid_reg;
    assign result_out.rotated_x = rx_reg;
    assign result_out.rotated_y = ry_reg;
    assign result_out.rotated_z = rz_reg;
    assign result_out.overflow  = ovf_reg;

endmodule
`default_nettype wire
